>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/fba_pkg.sv
// ---------------------------------------------------------------------------
// fba_pkg
// Types, codes and helpers shared by the frame bitmap allocator files.
// ---------------------------------------------------------------------------
package fba_pkg;

	// Fixed field and word widths.
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	localparam int FRAME_W   = 12;
	localparam int COUNT_W   = 13;
	localparam int FLAGS_W   = 3;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_ALLOC    = 2'd0,
		STATUS_FREED    = 2'd1,
		STATUS_IGNORED  = 2'd2,
		STATUS_NO_FRAME = 2'd3
	} status_t;

	// Index of the lowest clear bit of a word. The word must not be all ones.
	function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] iso;
		logic [BIT_W-1:0]     idx;
		iso = ~w & (w + WORD_BITS'(1));
		idx = '0;
		for (int j = 0; j < BIT_W; j++) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (((i >> j) & 1) == 1) begin
					idx[j] = idx[j] | iso[i];
				end
			end
		end
		return idx;
	endfunction

endpackage

>>> src/frame_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// frame_bitmap_allocator: first-fit frame allocator, one word in flight at a time.
// A free reads and rewrites its bitmap word, an ignored request goes straight to the result,
// an allocate reads words until one has a clear bit or none remain; stalls delay results.
// Next request taken once a result is out; reset clears one bitmap word a cycle (128 words).
// ---------------------------------------------------------------------------
module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fba_pkg::COUNT_W-1:0] cfg_data,
	// Request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [fba_pkg::FLAGS_W-1:0] flags,
	input  logic [fba_pkg::FRAME_W-1:0] current_frame,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fba_pkg::FRAME_W-1:0] frame,
	output logic                        present,
	output logic                        writable,
	output logic                        user_access,
	output logic [1:0]                  status
);

	// Bitmap geometry derived from the number of frames.
	localparam int MAP_WORDS   = (MAX_FRAMES + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;
	localparam int FLOOR_WORDS = MAX_FRAMES / fba_pkg::WORD_BITS;
	localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CW          = ($clog2(MAP_WORDS + 1) > 9) ? $clog2(MAP_WORDS + 1) : 9;
	localparam int XW          = (AW > 7) ? AW : 7;
	localparam int CMPW        = 21;
	localparam logic [CW-1:0]   FLOOR_LIM = CW'(FLOOR_WORDS);
	localparam logic [CW-1:0]   LAST_WORD = CW'(MAP_WORDS - 1);
	localparam logic [CMPW-1:0] MAX_X     = CMPW'(MAX_FRAMES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t state_q;

	// Bitmap memory and its ports.
	logic [fba_pkg::WORD_BITS-1:0] bitmap_mem [MAP_WORDS];
	logic [fba_pkg::WORD_BITS-1:0] rd_q;
	logic                          mem_we;
	logic [AW-1:0]                 mem_wa;
	logic [fba_pkg::WORD_BITS-1:0] mem_wd;
	logic                          mem_re;
	logic [AW-1:0]                 mem_ra;

	// Configuration and request registers.
	logic [fba_pkg::COUNT_W-1:0] frame_count_q;
	logic [fba_pkg::FLAGS_W-1:0] flags_q;
	logic [AW-1:0]               free_word_q;
	logic [fba_pkg::BIT_W-1:0]   free_bit_q;

	// Search and clearing counter, and the word under inspection.
	logic [CW-1:0] cnt_q;
	logic          chk_s1;
	logic [AW-1:0] word_s1;

	// Result held until the output register is free, and the output register.
	logic [fba_pkg::FRAME_W-1:0] res_frame_q;
	logic [fba_pkg::FLAGS_W-1:0] res_flags_q;
	fba_pkg::status_t            res_status_q;
	logic                        out_valid_q;
	logic [fba_pkg::FRAME_W-1:0] frame_q;
	logic [fba_pkg::FLAGS_W-1:0] flags_out_q;
	fba_pkg::status_t            status_q;

	// Request decode at the input port.
	logic                 accept;
	logic                 cur_zero;
	logic                 cur_oob;
	logic [XW-1:0]        cur_word_x;
	logic [CW-1:0]        fc_words;
	logic [CW-1:0]        limit;
	logic                 issue;
	logic                 found;
	logic [fba_pkg::BIT_W-1:0] hit_bit;
	logic                 out_free;

	assign accept     = in_valid && !in_stall;
	assign cur_zero   = (current_frame == '0);
	assign cur_oob    = (CMPW'(current_frame) >= MAX_X);
	assign cur_word_x = XW'(current_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W]);

	// Number of whole words searched, limited to the words held.
	assign fc_words = CW'(frame_count_q[fba_pkg::COUNT_W-1:fba_pkg::BIT_W]);
	assign limit    = (fc_words > FLOOR_LIM) ? FLOOR_LIM : fc_words;

	// Search: a read issues while words remain; a word with a clear bit ends it.
	assign issue   = (cnt_q < limit);
	assign found   = chk_s1 && (rd_q != '1);
	assign hit_bit = fba_pkg::lowest_clear(rd_q);

	assign out_free = !out_valid_q || !out_stall;

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[AW-1:0];
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = cnt_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_FREE_RD: begin
				mem_re = 1'b1;
				mem_ra = free_word_q;
			end
			ST_FREE_WR: begin
				mem_we = 1'b1;
				mem_wa = free_word_q;
				mem_wd = rd_q & ~(fba_pkg::WORD_BITS'(1) << free_bit_q);
			end
			ST_SEARCH: begin
				mem_re = issue && !found;
				mem_we = found;
				mem_wa = word_s1;
				mem_wd = rd_q | (fba_pkg::WORD_BITS'(1) << hit_bit);
			end
			default: begin
			end
		endcase
	end

	// Bitmap storage with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= bitmap_mem[mem_ra];
		end
	end

	// Sequencer, result and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			frame_count_q <= fba_pkg::COUNT_W'(4096);
			flags_q       <= '0;
			free_word_q   <= '0;
			free_bit_q    <= '0;
			cnt_q         <= '0;
			chk_s1        <= 1'b0;
			word_s1       <= '0;
			res_frame_q   <= '0;
			res_flags_q   <= '0;
			res_status_q  <= fba_pkg::STATUS_IGNORED;
			out_valid_q   <= 1'b0;
			frame_q       <= '0;
			flags_out_q   <= '0;
			status_q      <= fba_pkg::STATUS_IGNORED;
		end else begin
			// Configuration writes are taken in every state.
			if (cfg_valid) begin
				frame_count_q <= cfg_data;
			end
			// A taken result word empties the output register unless a new one follows.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						flags_q      <= flags;
						free_word_q  <= cur_word_x[AW-1:0];
						free_bit_q   <= current_frame[fba_pkg::BIT_W-1:0];
						cnt_q        <= '0;
						chk_s1       <= 1'b0;
						res_frame_q  <= '0;
						res_flags_q  <= '0;
						res_status_q <= fba_pkg::STATUS_IGNORED;
						if (cmd == fba_pkg::CMD_ALLOC) begin
							state_q <= cur_zero ? ST_SEARCH : ST_DONE;
						end else begin
							state_q <= (cur_zero || cur_oob) ? ST_DONE : ST_FREE_RD;
						end
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_WR;
				end
				ST_FREE_WR: begin
					res_status_q <= fba_pkg::STATUS_FREED;
					state_q      <= ST_DONE;
				end
				ST_SEARCH: begin
					if (found) begin
						res_frame_q  <= fba_pkg::FRAME_W'({word_s1, hit_bit});
						res_flags_q  <= flags_q;
						res_status_q <= fba_pkg::STATUS_ALLOC;
						state_q      <= ST_DONE;
					end else if (!chk_s1 && !issue) begin
						res_status_q <= fba_pkg::STATUS_NO_FRAME;
						state_q      <= ST_DONE;
					end else begin
						if (issue) begin
							cnt_q <= cnt_q + CW'(1);
						end
						chk_s1  <= issue;
						word_s1 <= cnt_q[AW-1:0];
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						frame_q     <= res_frame_q;
						flags_out_q <= res_flags_q;
						status_q    <= res_status_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Port drive.
	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign frame       = frame_q;
	assign present     = flags_out_q[0];
	assign writable    = flags_out_q[1];
	assign user_access = flags_out_q[2];
	assign status      = status_q;

endmodule

>>> src/fba_checker.sv
// ---------------------------------------------------------------------------
// fba_checker
// Port-level checks on the frame bitmap allocator, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [fba_pkg::FRAME_W-1:0] frame,
	input logic                        present,
	input logic                        writable,
	input logic                        user_access,
	input logic [1:0]                  status
);

	logic not_alloc;
	logic fields_zero;
	logic in_acc;
	logic out_wait;
	assign not_alloc   = (status != fba_pkg::STATUS_ALLOC);
	assign fields_zero = (frame == '0) && !present && !writable && !user_access;
	assign in_acc      = in_valid && !in_stall;
	assign out_wait    = out_valid && out_stall;

	// A stalled result word stays offered, with its frame and status unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(frame) && $stable(status))

	// The block works on one word at a time: an accepted request stalls the next.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_acc, in_stall)

	// Only a successful allocation returns a frame or page bits.
	`ASSERT_SAME(a_zero_fields, clk, arst_n, out_valid && not_alloc, fields_zero)

	// A result word cannot appear in the cycle right after a request is taken.
	`ASSERT_NEXT(a_no_early_result, clk, arst_n, in_acc && !out_valid, !out_valid)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: frame_bitmap_allocator
// Drives allocate and free requests into the allocator and checks each result
// against a cycle-free predictor that keeps its own copy of the used-frame
// bitmap and of the frame count. A directed part covers the flag decodes,
// ignored requests, frame zero and the frame count extremes. Random phases
// then work small pools to exhaustion, run without idling, and hold the
// result side off long enough to back the block up.
// ---------------------------------------------------------------------------
module testbench;

	localparam int TB_MAX_FRAMES = 4096;
	localparam int MAP_ENTRIES   = (TB_MAX_FRAMES + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int END_PAUSE     = 150;
	localparam int PRINT_LIMIT   = 40;

	// One expected result word.
	typedef struct packed {
		logic [fba_pkg::FRAME_W-1:0] frame;
		logic                        present;
		logic                        writable;
		logic                        user_access;
		fba_pkg::status_t            status;
	} frame_result_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_valid     = 1'b0;
	logic                          cfg_ready;
	logic [fba_pkg::COUNT_W-1:0]   cfg_data      = '0;
	logic                          in_valid      = 1'b0;
	logic                          in_stall;
	logic                          cmd           = fba_pkg::CMD_ALLOC;
	logic [fba_pkg::FLAGS_W-1:0]   flags         = '0;
	logic [fba_pkg::FRAME_W-1:0]   current_frame = '0;
	logic                          out_valid;
	logic                          out_stall     = 1'b0;
	logic [fba_pkg::FRAME_W-1:0]   frame;
	logic                          present;
	logic                          writable;
	logic                          user_access;
	logic [1:0]                    status;

	// Predictor state: used-frame bitmap and the managed frame count.
	logic [fba_pkg::WORD_BITS-1:0] used_map [MAP_ENTRIES];
	logic [fba_pkg::COUNT_W-1:0]   managed_frames;

	frame_result_t                 expected_results [$];
	logic [fba_pkg::FRAME_W-1:0]   live_frames [$];

	bit                   tx_idle_on    = 1'b1;
	bit                   rx_idle_on    = 1'b1;
	int                   hold_cycles   = 0;
	int                   cycle_count   = 0;
	int                   error_count   = 0;
	int                   results_seen  = 0;
	int                   requests_sent = 0;
	int                   count_writes  = 0;
	int                   status_tally [4] = '{0, 0, 0, 0};

	frame_bitmap_allocator #(
		.MAX_FRAMES(TB_MAX_FRAMES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.flags        (flags),
		.current_frame(current_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame        (frame),
		.present      (present),
		.writable     (writable),
		.user_access  (user_access),
		.status       (status)
	);

	// Free-running clock, period 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit; reaching it means the block has hung.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
			cycle_count, expected_results.size());
		$display("Some tests failed");
		$finish;
	end

	// Prints one line per mismatch, up to a cap, and counts them all.
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("MISMATCH (cycle %0d): %s", cycle_count, msg);
		end
	endtask

	// First-fit allocate or free against the predictor's bitmap.
	function automatic frame_result_t predict_frame_op(input logic op,
			input logic [fba_pkg::FLAGS_W-1:0] fl, input logic [fba_pkg::FRAME_W-1:0] cur);
		frame_result_t r;
		int            words;
		bit            found;
		r.frame       = '0;
		r.present     = 1'b0;
		r.writable    = 1'b0;
		r.user_access = 1'b0;
		r.status      = fba_pkg::STATUS_IGNORED;
		found         = 1'b0;
		if (op == fba_pkg::CMD_ALLOC) begin
			if (cur != '0) begin
				return r;
			end
			// Only whole words are searched, and never past the bitmap.
			words = int'(managed_frames) / fba_pkg::WORD_BITS;
			if (words > MAP_ENTRIES) begin
				words = MAP_ENTRIES;
			end
			for (int w = 0; w < words && !found; w++) begin
				if (used_map[w] != '1) begin
					for (int b = 0; b < fba_pkg::WORD_BITS && !found; b++) begin
						if (!used_map[w][b]) begin
							used_map[w][b] = 1'b1;
							r.frame        = fba_pkg::FRAME_W'(w * fba_pkg::WORD_BITS + b);
							found          = 1'b1;
						end
					end
				end
			end
			if (found) begin
				r.present     = fl[0];
				r.writable    = fl[1];
				r.user_access = fl[2];
				r.status      = fba_pkg::STATUS_ALLOC;
			end else begin
				r.status = fba_pkg::STATUS_NO_FRAME;
			end
		end else if (cur != '0 && int'(cur) < TB_MAX_FRAMES) begin
			// A free clears the bit whether or not it was set.
			used_map[int'(cur) / fba_pkg::WORD_BITS][int'(cur) % fba_pkg::WORD_BITS] = 1'b0;
			r.status = fba_pkg::STATUS_FREED;
		end
		return r;
	endfunction

	// Offers one request word, holds it until taken, then predicts its result.
	task automatic send_request(input logic op, input logic [fba_pkg::FLAGS_W-1:0] fl,
			input logic [fba_pkg::FRAME_W-1:0] cur);
		frame_result_t r;
		if (tx_idle_on && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		flags         <= fl;
		current_frame <= cur;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		r = predict_frame_op(op, fl, cur);
		expected_results.push_back(r);
		requests_sent++;
		status_tally[r.status]++;
		// Keep the list of frames handed out, for well-formed frees.
		if (r.status == fba_pkg::STATUS_ALLOC) begin
			live_frames.push_back(r.frame);
		end else if (r.status == fba_pkg::STATUS_FREED) begin
			for (int i = 0; i < live_frames.size(); i++) begin
				if (live_frames[i] == cur) begin
					live_frames.delete(i);
					break;
				end
			end
		end
	endtask

	// Stops offering words and waits until every result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes the frame count register once the block is idle.
	task automatic write_frame_count(input logic [fba_pkg::COUNT_W-1:0] count);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid      <= 1'b0;
		managed_frames  = count;
		count_writes++;
	endtask

	// Mostly well-formed traffic: allocations for unmapped pages and frees of
	// frames handed out earlier, with some ignored or odd requests mixed in.
	task automatic random_requests(input int n, input int alloc_pct);
		int                          pick;
		logic [fba_pkg::FLAGS_W-1:0] fl;
		logic [fba_pkg::FRAME_W-1:0] cur;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			fl   = fba_pkg::FLAGS_W'($urandom_range(0, 7));
			if (pick < alloc_pct) begin
				send_request(fba_pkg::CMD_ALLOC, fl, '0);
			end else if (pick < 85 && live_frames.size() != 0) begin
				cur = live_frames[$urandom_range(0, live_frames.size() - 1)];
				send_request(fba_pkg::CMD_FREE, fl, cur);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						cur = fba_pkg::FRAME_W'($urandom_range(1, 4095));
						send_request(fba_pkg::CMD_ALLOC, fl, cur);
					end
					1: begin
						cur = fba_pkg::FRAME_W'($urandom_range(0, 4095));
						send_request(fba_pkg::CMD_FREE, fl, cur);
					end
					2: begin
						send_request(fba_pkg::CMD_FREE, fl, '0);
					end
					default: begin
						cur = fba_pkg::FRAME_W'($urandom_range(1, 127));
						send_request(fba_pkg::CMD_FREE, fl, cur);
					end
				endcase
			end
		end
	endtask

	// Flag decodes, frame zero, ignored requests and frees of unused frames.
	task automatic test_directed_requests();
		for (int f = 0; f < 8; f++) begin
			send_request(fba_pkg::CMD_ALLOC, fba_pkg::FLAGS_W'(f), '0);
		end
		send_request(fba_pkg::CMD_ALLOC, 3'b111, 12'hFFF);
		send_request(fba_pkg::CMD_ALLOC, 3'b111, 12'h001);
		send_request(fba_pkg::CMD_FREE, 3'b111, '0);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'd3);
		send_request(fba_pkg::CMD_ALLOC, 3'b101, '0);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'hFFF);
		send_request(fba_pkg::CMD_FREE, 3'b010, 12'd2048);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'd3);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'd3);
		send_request(fba_pkg::CMD_ALLOC, 3'b110, '0);
	endtask

	// No word searched, a count just short of one word, one word, oversized.
	task automatic test_count_extremes();
		write_frame_count('0);
		send_request(fba_pkg::CMD_ALLOC, 3'b111, '0);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'd5);
		send_request(fba_pkg::CMD_ALLOC, 3'b001, '0);
		write_frame_count(13'd31);
		send_request(fba_pkg::CMD_ALLOC, 3'b011, '0);
		write_frame_count(13'd32);
		send_request(fba_pkg::CMD_ALLOC, 3'b100, '0);
		write_frame_count('1);
		send_request(fba_pkg::CMD_ALLOC, 3'b010, '0);
		send_request(fba_pkg::CMD_FREE, 3'b000, 12'd4000);
	endtask

	// A small pool with a partial last word, run to exhaustion again and again.
	task automatic test_small_pool();
		write_frame_count(13'd40);
		random_requests(300, 65);
	endtask

	// Oversized count, neither side idling for the whole phase.
	task automatic test_no_idle_stretch();
		write_frame_count(13'd8000);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_requests(250, 55);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// The result side holds off while requests keep coming.
	task automatic test_backpressure();
		write_frame_count(13'd96);
		@(negedge clk);
		hold_cycles = 400;
		@(posedge clk);
		random_requests(40, 50);
	endtask

	// Default size, then a few random counts.
	task automatic test_random_sizes();
		write_frame_count(13'd4096);
		random_requests(500, 55);
		repeat (3) begin
			write_frame_count(fba_pkg::COUNT_W'($urandom_range(32, 600)));
			random_requests(60, 60);
		end
	endtask

	// Result side: random stalls, or a long hold when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else if (rx_idle_on) begin
			out_stall <= ($urandom_range(0, 99) < 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result check, sampled on the falling edge ahead of the accepting edge.
	always @(negedge clk) begin : result_checker
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result frame %0d status %0d with nothing expected",
					frame, status));
			end else begin
				want = expected_results.pop_front();
				if (frame !== want.frame) begin
					report_mismatch($sformatf("frame %0d, expected %0d", frame, want.frame));
				end
				if (present !== want.present) begin
					report_mismatch($sformatf("present %b, expected %b", present, want.present));
				end
				if (writable !== want.writable) begin
					report_mismatch($sformatf("writable %b, expected %b", writable, want.writable));
				end
				if (user_access !== want.user_access) begin
					report_mismatch($sformatf("user_access %b, expected %b",
						user_access, want.user_access));
				end
				if (status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				end
			end
		end
	end

	// Test sequence.
	initial begin
		for (int w = 0; w < MAP_ENTRIES; w++) begin
			used_map[w] = '0;
		end
		managed_frames = 13'd4096;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_requests();
		test_count_extremes();
		test_small_pool();
		test_no_idle_stretch();
		test_backpressure();
		test_random_sizes();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (END_PAUSE) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end

		$display("Sent %0d requests across %0d frame count settings; %0d results checked.",
			requests_sent, count_writes, results_seen);
		$display("Outcomes: %0d allocated, %0d freed, %0d ignored, %0d with no free frame.",
			status_tally[fba_pkg::STATUS_ALLOC], status_tally[fba_pkg::STATUS_FREED],
			status_tally[fba_pkg::STATUS_IGNORED], status_tally[fba_pkg::STATUS_NO_FRAME]);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
